// ===== rtl/core/bst_pkg.sv =====
package bst_pkg;

    localparam int VAL_W     = 17;
    localparam int FRAC_BITS = 16;
    localparam int QUOT_W    = 18;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int DIVD_W    = PROD_W + 1;
    localparam int CNT_W     = 4;
    localparam int IDX_W     = 6;
    localparam int SUM_W     = 8;
    localparam int DEG_W     = 3;
    localparam int UNIQ_W    = 7;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;

    typedef logic [VAL_W-1:0] val_t;

    localparam val_t ONE_FX = val_t'(1 << FRAC_BITS);

    localparam logic [MODE_W-1:0] MODE_LOAD_U = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_V = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EVAL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_U = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_V = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIQUE_U = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIQUE_V = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_INIT_RD,
        S_INIT_WR,
        S_TERM_RD1,
        S_TERM_RD2,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_FIN_RD,
        S_FIN,
        S_PROD,
        S_OUT
    } seq_state_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_PREP,
        D_ITER
    } div_state_t;

    typedef struct packed {
        logic start;
        val_t num;
        val_t den;
        val_t prev;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

    function automatic val_t pos_diff(input val_t a, input val_t b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

// ===== rtl/core/bst_knot_mem.sv =====
module bst_knot_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic [bst_pkg::VAL_W-1:0] wdata,
    input  logic [AW-1:0]           raddr_a,
    input  logic [AW-1:0]           raddr_b,
    output logic [bst_pkg::VAL_W-1:0] rdata_a,
    output logic [bst_pkg::VAL_W-1:0] rdata_b
);
    import bst_pkg::*;

    val_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/core/bst_divider.sv =====
module bst_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  bst_pkg::div_req_t req,
    output bst_pkg::div_rsp_t rsp
);
    import bst_pkg::*;

    localparam int BIT_W = $clog2(QUOT_W);

    div_state_t          state_reg, state_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    val_t                den_reg, den_next;
    logic [DIVD_W-1:0]   dvd_reg, dvd_next;
    val_t                rem_reg, rem_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                done_reg, done_next;
    logic [QUOT_W-1:0]   dvd_lo;
    logic [VAL_W:0]      trial;
    logic                zero_op;
    logic                ovf;

    assign dvd_lo  = dvd_reg[QUOT_W-1:0];
    assign trial   = {rem_reg, dvd_lo[bit_reg]};
    assign zero_op = (req.num == '0) || (req.den == '0) || (req.prev == '0);
    // A quotient that does not fit saturates; the caller clamps the sum at one anyway.
    assign ovf     = (dvd_reg[DIVD_W-1:QUOT_W] >= den_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start && !zero_op)
                begin
                    state_next = D_MUL;
                end
            end
            D_MUL:  state_next = D_PREP;
            D_PREP: state_next = ovf ? D_IDLE : D_ITER;
            D_ITER:
            begin
                if (bit_reg == '0)
                begin
                    state_next = D_IDLE;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_comb
    begin
        prod_next = prod_reg;
        den_next  = den_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        bit_next  = bit_reg;
        done_next = 1'b0;
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    if (zero_op)
                    begin
                        quot_next = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        prod_next = req.num * req.prev;
                        den_next  = req.den;
                    end
                end
            end
            D_MUL:
            begin
                dvd_next = {1'b0, prod_reg} + DIVD_W'(den_reg >> 1);
            end
            D_PREP:
            begin
                if (ovf)
                begin
                    quot_next = '1;
                    done_next = 1'b1;
                end
                else
                begin
                    rem_next  = dvd_reg[DIVD_W-1:QUOT_W];
                    quot_next = '0;
                    bit_next  = BIT_W'(QUOT_W - 1);
                end
            end
            D_ITER:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next  = VAL_W'(trial - {1'b0, den_reg});
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[VAL_W-1:0];
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    done_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        den_reg  <= den_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        bit_reg  <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== rtl/core/bst_seq.sv =====
module bst_seq #(
    parameter int MAX_KNOTS  = 64,
    parameter int MAX_DEGREE = 7,
    parameter int AW         = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start_eval,
    input  logic [bst_pkg::IDX_W-1:0]   row_index,
    input  logic [bst_pkg::IDX_W-1:0]   col_index,
    input  logic [bst_pkg::VAL_W-1:0]   u_param,
    input  logic [bst_pkg::VAL_W-1:0]   v_param,
    input  logic [bst_pkg::DEG_W-1:0]   degree_u,
    input  logic [bst_pkg::DEG_W-1:0]   degree_v,
    input  logic [bst_pkg::UNIQ_W-1:0]  unique_knots_u,
    input  logic [bst_pkg::UNIQ_W-1:0]  unique_knots_v,
    input  logic [bst_pkg::VAL_W-1:0]   knot_u_a,
    input  logic [bst_pkg::VAL_W-1:0]   knot_u_b,
    input  logic [bst_pkg::VAL_W-1:0]   knot_v_a,
    input  logic [bst_pkg::VAL_W-1:0]   knot_v_b,
    output logic [AW-1:0]               knot_addr_a,
    output logic [AW-1:0]               knot_addr_b,
    output logic                        busy,
    output logic                        done,
    output logic [bst_pkg::VAL_W-1:0]   basis_u_value,
    output logic [bst_pkg::VAL_W-1:0]   basis_v_value,
    output logic [bst_pkg::VAL_W-1:0]   product_value,
    output logic                        index_error
);
    import bst_pkg::*;

    localparam int NDEPTH = MAX_DEGREE + 1;
    localparam int NW     = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
    localparam logic [CNT_W-1:0] DEG_MAX = CNT_W'(MAX_DEGREE);

    seq_state_t          state_reg, state_next;
    logic                dir_reg, dir_next;
    logic [IDX_W-1:0]    row_reg, row_next, col_reg, col_next, idx_reg, idx_next;
    val_t                u_reg, u_next, v_reg, v_next, t_reg, t_next;
    logic [CNT_W-1:0]    deg_reg, deg_next, j_reg, j_next, q_reg, q_next;
    val_t                ka_reg, ka_next, kaq_reg, kaq_next;
    val_t                ka1_reg, ka1_next, kaq1_reg, kaq1_next;
    val_t                n0_reg, n0_next, n1_reg, n1_next;
    logic [QUOT_W-1:0]   s1_reg, s1_next;
    val_t                bu_reg, bu_next, bv_reg, bv_next;
    logic                err_reg, err_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    val_t                out_u_reg, out_u_next, out_v_reg, out_v_next, out_p_reg, out_p_next;
    logic                out_err_reg, out_err_next;
    logic                done_reg, done_next;

    val_t                n_mem [NDEPTH];
    val_t                n_rd_a, n_rd_b;
    logic [NW-1:0]       n_raddr_a, n_raddr_b, n_waddr;
    logic                n_we;
    val_t                n_wdata;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    val_t                knot_a, knot_b;
    logic [IDX_W-1:0]    set_idx;
    val_t                set_t;
    logic [DEG_W-1:0]    set_deg_raw;
    logic [UNIQ_W-1:0]   set_uniq;
    logic [CNT_W-1:0]    set_deg;
    logic [SUM_W-1:0]    supp, total;
    logic                set_err, set_last;
    logic [SUM_W-1:0]    addr_j, addr_jq;
    logic [SUM_W-1:0]    jq_next_sum;
    logic [QUOT_W:0]     term_sum;
    val_t                term_sat;
    logic                init_hit;
    logic [PROD_W-1:0]   prod_round;

    bst_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign knot_a = dir_reg ? knot_v_a : knot_u_a;
    assign knot_b = dir_reg ? knot_v_b : knot_u_b;

    assign set_idx     = dir_reg ? col_reg : row_reg;
    assign set_t       = dir_reg ? v_reg : u_reg;
    assign set_deg_raw = dir_reg ? degree_v : degree_u;
    assign set_uniq    = dir_reg ? unique_knots_v : unique_knots_u;
    assign set_deg     = (CNT_W'(set_deg_raw) > DEG_MAX) ? DEG_MAX : CNT_W'(set_deg_raw);
    assign supp        = SUM_W'(set_idx) + SUM_W'(set_deg) + SUM_W'(1);
    assign total       = SUM_W'(set_uniq) + SUM_W'(set_deg) + SUM_W'(set_deg);
    assign set_err     = (supp >= total) || (int'(supp) >= MAX_KNOTS);
    // The last basis function closes the interval at one.
    assign set_last    = ((SUM_W'(set_idx) + SUM_W'(2)) == (SUM_W'(set_uniq) + SUM_W'(set_deg)))
                         && (set_t == ONE_FX);

    assign addr_j      = SUM_W'(idx_reg) + SUM_W'(j_reg);
    assign addr_jq     = addr_j + SUM_W'(q_reg);
    assign jq_next_sum = SUM_W'(j_reg) + SUM_W'(q_reg) + SUM_W'(1);
    assign term_sum    = {1'b0, s1_reg} + {1'b0, div_rsp.quot};
    assign term_sat    = (term_sum > (QUOT_W+1)'(ONE_FX)) ? ONE_FX : VAL_W'(term_sum);
    assign init_hit    = (knot_a <= t_reg) && (t_reg < knot_b);
    assign prod_round  = prod_reg + PROD_W'(1 << (FRAC_BITS - 1));

    always_comb
    begin
        knot_addr_a = '0;
        knot_addr_b = '0;
        case (state_reg)
            S_INIT_RD:
            begin
                knot_addr_a = AW'(addr_j);
                knot_addr_b = AW'(addr_j + SUM_W'(1));
            end
            S_TERM_RD1:
            begin
                knot_addr_a = AW'(addr_j);
                knot_addr_b = AW'(addr_jq);
            end
            S_TERM_RD2:
            begin
                knot_addr_a = AW'(addr_j + SUM_W'(1));
                knot_addr_b = AW'(addr_jq + SUM_W'(1));
            end
            default: ;
        endcase
    end

    assign n_raddr_a = (state_reg == S_FIN_RD) ? '0 : NW'(j_reg);
    assign n_raddr_b = NW'(j_reg + CNT_W'(1));
    assign n_waddr   = NW'(j_reg);
    assign n_we      = (state_reg == S_INIT_WR)
                       || ((state_reg == S_DIV2_WAIT) && div_rsp.done);
    assign n_wdata   = (state_reg == S_INIT_WR) ? (init_hit ? ONE_FX : '0) : term_sat;

    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            n_mem[n_waddr] <= n_wdata;
        end
        n_rd_a <= n_mem[n_raddr_a];
        n_rd_b <= n_mem[n_raddr_b];
    end

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        div_req.prev  = '0;
        case (state_reg)
            S_DIV1_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = pos_diff(t_reg, ka_reg);
                div_req.den   = pos_diff(kaq_reg, ka_reg);
                div_req.prev  = n0_reg;
            end
            S_DIV2_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = pos_diff(kaq1_reg, t_reg);
                div_req.den   = pos_diff(kaq1_reg, ka1_reg);
                div_req.prev  = n1_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (start_eval) state_next = S_SETUP;
            S_SETUP:
            begin
                if (set_err || set_last)
                begin
                    state_next = dir_reg ? S_PROD : S_SETUP;
                end
                else
                begin
                    state_next = S_INIT_RD;
                end
            end
            S_INIT_RD:   state_next = S_INIT_WR;
            S_INIT_WR:
            begin
                if (j_reg != deg_reg)
                begin
                    state_next = S_INIT_RD;
                end
                else
                begin
                    state_next = (deg_reg == '0) ? S_FIN_RD : S_TERM_RD1;
                end
            end
            S_TERM_RD1:  state_next = S_TERM_RD2;
            S_TERM_RD2:  state_next = S_DIV1_GO;
            S_DIV1_GO:   state_next = S_DIV1_WAIT;
            S_DIV1_WAIT: if (div_rsp.done) state_next = S_DIV2_GO;
            S_DIV2_GO:   state_next = S_DIV2_WAIT;
            S_DIV2_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (jq_next_sum <= SUM_W'(deg_reg))
                    begin
                        state_next = S_TERM_RD1;
                    end
                    else
                    begin
                        state_next = (q_reg == deg_reg) ? S_FIN_RD : S_TERM_RD1;
                    end
                end
            end
            S_FIN_RD:    state_next = S_FIN;
            S_FIN:       state_next = dir_reg ? S_PROD : S_SETUP;
            S_PROD:      state_next = S_OUT;
            S_OUT:       state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        dir_next     = dir_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        idx_next     = idx_reg;
        t_next       = t_reg;
        deg_next     = deg_reg;
        j_next       = j_reg;
        q_next       = q_reg;
        ka_next      = ka_reg;
        kaq_next     = kaq_reg;
        ka1_next     = ka1_reg;
        kaq1_next    = kaq1_reg;
        n0_next      = n0_reg;
        n1_next      = n1_reg;
        s1_next      = s1_reg;
        bu_next      = bu_reg;
        bv_next      = bv_reg;
        err_next     = err_reg;
        prod_next    = prod_reg;
        out_u_next   = out_u_reg;
        out_v_next   = out_v_reg;
        out_p_next   = out_p_reg;
        out_err_next = out_err_reg;
        done_next    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start_eval)
                begin
                    row_next = row_index;
                    col_next = col_index;
                    u_next   = u_param;
                    v_next   = v_param;
                    dir_next = 1'b0;
                    err_next = 1'b0;
                end
            end
            S_SETUP:
            begin
                idx_next = set_idx;
                t_next   = set_t;
                deg_next = set_deg;
                j_next   = '0;
                if (set_err || set_last)
                begin
                    if (set_err)
                    begin
                        err_next = 1'b1;
                    end
                    if (dir_reg)
                    begin
                        bv_next = set_err ? '0 : ONE_FX;
                    end
                    else
                    begin
                        bu_next = set_err ? '0 : ONE_FX;
                    end
                    dir_next = 1'b1;
                end
            end
            S_INIT_WR:
            begin
                if (j_reg != deg_reg)
                begin
                    j_next = j_reg + CNT_W'(1);
                end
                else
                begin
                    j_next = '0;
                    q_next = CNT_W'(1);
                end
            end
            S_TERM_RD2:
            begin
                ka_next  = knot_a;
                kaq_next = knot_b;
                n0_next  = n_rd_a;
                n1_next  = n_rd_b;
            end
            S_DIV1_GO:
            begin
                ka1_next  = knot_a;
                kaq1_next = knot_b;
            end
            S_DIV1_WAIT:
            begin
                if (div_rsp.done)
                begin
                    s1_next = div_rsp.quot;
                end
            end
            S_DIV2_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (jq_next_sum <= SUM_W'(deg_reg))
                    begin
                        j_next = j_reg + CNT_W'(1);
                    end
                    else
                    begin
                        j_next = '0;
                        q_next = q_reg + CNT_W'(1);
                    end
                end
            end
            S_FIN:
            begin
                if (dir_reg)
                begin
                    bv_next = n_rd_a;
                end
                else
                begin
                    bu_next = n_rd_a;
                end
                dir_next = 1'b1;
            end
            S_PROD:
            begin
                prod_next = bu_reg * bv_reg;
            end
            S_OUT:
            begin
                out_u_next   = bu_reg;
                out_v_next   = bv_reg;
                out_p_next   = VAL_W'(prod_round >> FRAC_BITS);
                out_err_next = err_reg;
                done_next    = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            dir_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            dir_reg   <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        col_reg     <= col_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        idx_reg     <= idx_next;
        t_reg       <= t_next;
        deg_reg     <= deg_next;
        j_reg       <= j_next;
        q_reg       <= q_next;
        ka_reg      <= ka_next;
        kaq_reg     <= kaq_next;
        ka1_reg     <= ka1_next;
        kaq1_reg    <= kaq1_next;
        n0_reg      <= n0_next;
        n1_reg      <= n1_next;
        s1_reg      <= s1_next;
        bu_reg      <= bu_next;
        bv_reg      <= bv_next;
        err_reg     <= err_next;
        prod_reg    <= prod_next;
        out_u_reg   <= out_u_next;
        out_v_reg   <= out_v_next;
        out_p_reg   <= out_p_next;
        out_err_reg <= out_err_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign basis_u_value = out_u_reg;
    assign basis_v_value = out_v_reg;
    assign product_value = out_p_reg;
    assign index_error   = out_err_reg;

endmodule

// ===== rtl/core/bspline_tensor_basis_eval.sv =====
// Evaluates one tensor-product B-spline basis value per evaluate request, using the
// Cox-de Boor triangle over knots held in two on-chip knot memories. Knot loads and
// mode-3 requests produce no result. An evaluate request keeps busy high while, per
// direction of degree d, the sequencer sets up, writes the d+1 starting entries, works
// through the triangle terms and reads the result (an index error or the last-function
// case at one sets the value at setup instead), then forms the product and the output.
// The evaluation time is set by the single shared divider, which produces one quotient
// bit a cycle (two divisions and two knot reads per triangle term; a division with a
// zero operand returns zero without iterating, and one whose quotient overflows ends
// early with a saturated quotient). The result appears for one cycle with
// done high, in the cycle after busy falls, and must be captured then; the block
// cannot be stalled by the receiver.
module bspline_tensor_basis_eval #(
    parameter int MAX_KNOTS  = 64,
    parameter int MAX_DEGREE = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    output logic                           done,
    input  logic                           cfg_we,
    input  logic [bst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bst_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic [bst_pkg::MODE_W-1:0]     mode,
    input  logic [bst_pkg::IDX_W-1:0]      knot_slot,
    input  logic [bst_pkg::VAL_W-1:0]      knot_value,
    input  logic [bst_pkg::IDX_W-1:0]      row_index,
    input  logic [bst_pkg::IDX_W-1:0]      col_index,
    input  logic [bst_pkg::VAL_W-1:0]      u_param,
    input  logic [bst_pkg::VAL_W-1:0]      v_param,
    output logic [bst_pkg::VAL_W-1:0]      basis_u_value,
    output logic [bst_pkg::VAL_W-1:0]      basis_v_value,
    output logic [bst_pkg::VAL_W-1:0]      product_value,
    output logic                           index_error
);
    import bst_pkg::*;

    localparam int AW = $clog2(MAX_KNOTS);

    logic [DEG_W-1:0]  degree_u_reg, degree_v_reg;
    logic [UNIQ_W-1:0] unique_u_reg, unique_v_reg;
    logic              accept, slot_ok, we_u, we_v, start_eval;
    logic [AW-1:0]     waddr, raddr_a, raddr_b;
    val_t              ku_a, ku_b, kv_a, kv_b;

    assign accept     = start && !busy;
    assign slot_ok    = (int'(knot_slot) < MAX_KNOTS);
    assign we_u       = accept && (mode == MODE_LOAD_U) && slot_ok;
    assign we_v       = accept && (mode == MODE_LOAD_V) && slot_ok;
    assign start_eval = accept && (mode == MODE_EVAL);
    assign waddr      = AW'(knot_slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_u_reg <= DEG_W'(3);
            degree_v_reg <= DEG_W'(3);
            unique_u_reg <= UNIQ_W'(2);
            unique_v_reg <= UNIQ_W'(2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEGREE_U: degree_u_reg <= cfg_wdata[DEG_W-1:0];
                CFG_DEGREE_V: degree_v_reg <= cfg_wdata[DEG_W-1:0];
                CFG_UNIQUE_U: unique_u_reg <= cfg_wdata[UNIQ_W-1:0];
                CFG_UNIQUE_V: unique_v_reg <= cfg_wdata[UNIQ_W-1:0];
                default: ;
            endcase
        end
    end

    bst_knot_mem #(.DEPTH(MAX_KNOTS), .AW(AW)) u_mem_u (
        .clk     (clk),
        .we      (we_u),
        .waddr   (waddr),
        .wdata   (knot_value),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (ku_a),
        .rdata_b (ku_b)
    );

    bst_knot_mem #(.DEPTH(MAX_KNOTS), .AW(AW)) u_mem_v (
        .clk     (clk),
        .we      (we_v),
        .waddr   (waddr),
        .wdata   (knot_value),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (kv_a),
        .rdata_b (kv_b)
    );

    bst_seq #(.MAX_KNOTS(MAX_KNOTS), .MAX_DEGREE(MAX_DEGREE), .AW(AW)) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start_eval     (start_eval),
        .row_index      (row_index),
        .col_index      (col_index),
        .u_param        (u_param),
        .v_param        (v_param),
        .degree_u       (degree_u_reg),
        .degree_v       (degree_v_reg),
        .unique_knots_u (unique_u_reg),
        .unique_knots_v (unique_v_reg),
        .knot_u_a       (ku_a),
        .knot_u_b       (ku_b),
        .knot_v_a       (kv_a),
        .knot_v_b       (kv_b),
        .knot_addr_a    (raddr_a),
        .knot_addr_b    (raddr_b),
        .busy           (busy),
        .done           (done),
        .basis_u_value  (basis_u_value),
        .basis_v_value  (basis_v_value),
        .product_value  (product_value),
        .index_error    (index_error)
    );

endmodule

// ===== rtl/core/bst_checker.sv =====
module bst_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic [bst_pkg::MODE_W-1:0]     mode,
    input logic [bst_pkg::VAL_W-1:0]      basis_u_value,
    input logic [bst_pkg::VAL_W-1:0]      basis_v_value,
    input logic [bst_pkg::VAL_W-1:0]      product_value
);
    import bst_pkg::*;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding busy period");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_EVAL)) |=> busy)
        else $error("evaluate request did not raise busy");

    a_prod_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((product_value <= basis_u_value) && (product_value <= basis_v_value)
                  && (basis_u_value <= ONE_FX) && (basis_v_value <= ONE_FX)))
        else $error("basis or product value out of range");

endmodule

bind bspline_tensor_basis_eval bst_checker u_bst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .mode          (mode),
    .basis_u_value (basis_u_value),
    .basis_v_value (basis_v_value),
    .product_value (product_value)
);

// ===== sim/bspline_tensor_basis_eval_checker.sv =====
`timescale 1ns / 100ps

module bspline_tensor_basis_eval_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          done,
    input  logic                          cfg_we,
    input  logic [bst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bst_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [bst_pkg::MODE_W-1:0]    mode,
    input  logic [bst_pkg::IDX_W-1:0]     knot_slot,
    input  logic [bst_pkg::VAL_W-1:0]     knot_value,
    input  logic [bst_pkg::IDX_W-1:0]     row_index,
    input  logic [bst_pkg::IDX_W-1:0]     col_index,
    input  logic [bst_pkg::VAL_W-1:0]     u_param,
    input  logic [bst_pkg::VAL_W-1:0]     v_param,
    input  logic [bst_pkg::VAL_W-1:0]     basis_u_value,
    input  logic [bst_pkg::VAL_W-1:0]     basis_v_value,
    input  logic [bst_pkg::VAL_W-1:0]     product_value,
    input  logic                          index_error,
    output int                            fail_count,
    output int                            pending
);
    import bst_pkg::*;

    typedef struct packed {
        val_t bu;
        val_t bv;
        val_t prod;
        logic err;
    } basis_result_t;

    basis_result_t    expected_basis[$];
    val_t             knots_u [0:63];
    val_t             knots_v [0:63];
    logic [DEG_W-1:0] deg_u, deg_v;
    logic [UNIQ_W-1:0] uniq_u, uniq_v;

    assign pending = expected_basis.size();

    function automatic longint unsigned weighted_term(input longint unsigned num,
                                                      input longint unsigned den,
                                                      input longint unsigned prev);
        if (num == 0 || den == 0 || prev == 0)
            return 0;
        return (num * prev + den / 2) / den;
    endfunction

    function automatic longint unsigned gap(input longint unsigned a,
                                            input longint unsigned b);
        return (a > b) ? a - b : 0;
    endfunction

    function automatic val_t basis_at(input logic dir_v, input int deg, input int uniq,
                                      input int idx, input longint unsigned t,
                                      inout logic err);
        longint unsigned n [0:7];
        longint unsigned k [0:63];
        longint unsigned s;
        int total;
        total = uniq + 2 * deg;
        for (int i = 0; i < 64; i++)
            k[i] = dir_v ? knots_v[i] : knots_u[i];
        if (idx + deg + 1 >= total || idx + deg + 1 >= 64) begin
            err = 1'b1;
            return '0;
        end
        // The last function is pinned to one at the right end of the domain.
        if (idx + 2 == uniq + deg && t == 65536)
            return ONE_FX;
        for (int j = 0; j <= deg; j++)
            n[j] = (k[idx+j] <= t && t < k[idx+j+1]) ? 65536 : 0;
        for (int q = 1; q <= deg; q++) begin
            for (int j = 0; j + q <= deg; j++) begin
                s = weighted_term(gap(t, k[idx+j]), gap(k[idx+j+q], k[idx+j]), n[j])
                  + weighted_term(gap(k[idx+j+q+1], t),
                                  gap(k[idx+j+q+1], k[idx+j+1]), n[j+1]);
                n[j] = (s > 65536) ? 65536 : s;
            end
        end
        return val_t'(n[0]);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        basis_result_t   e, got;
        longint unsigned p;
        if (!rst_n) begin
            deg_u = 3;
            deg_v = 3;
            uniq_u = 2;
            uniq_v = 2;
            fail_count = 0;
            expected_basis.delete();
            for (int i = 0; i < 64; i++) begin
                knots_u[i] = '0;
                knots_v[i] = '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DEGREE_U: deg_u = cfg_wdata[DEG_W-1:0];
                    CFG_DEGREE_V: deg_v = cfg_wdata[DEG_W-1:0];
                    CFG_UNIQUE_U: uniq_u = cfg_wdata[UNIQ_W-1:0];
                    CFG_UNIQUE_V: uniq_v = cfg_wdata[UNIQ_W-1:0];
                    default: ;
                endcase
            end
            // Compare the strobed result before queueing a request taken at this edge.
            if (done) begin
                got = '{basis_u_value, basis_v_value, product_value, index_error};
                if (expected_basis.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, got);
                    fail_count++;
                end else begin
                    e = expected_basis.pop_front();
                    if (got.bu !== e.bu) begin
                        $display("%0t: basis_u_value expected %0d actual %0d",
                                 $time, e.bu, got.bu);
                        fail_count++;
                    end
                    if (got.bv !== e.bv) begin
                        $display("%0t: basis_v_value expected %0d actual %0d",
                                 $time, e.bv, got.bv);
                        fail_count++;
                    end
                    if (got.prod !== e.prod) begin
                        $display("%0t: product_value expected %0d actual %0d",
                                 $time, e.prod, got.prod);
                        fail_count++;
                    end
                    if (got.err !== e.err) begin
                        $display("%0t: index_error expected %0d actual %0d",
                                 $time, e.err, got.err);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                if (mode == MODE_LOAD_U)
                    knots_u[knot_slot] = knot_value;
                else if (mode == MODE_LOAD_V)
                    knots_v[knot_slot] = knot_value;
                else if (mode == MODE_EVAL) begin
                    e.err = 1'b0;
                    e.bu = basis_at(1'b0, deg_u, uniq_u, row_index, u_param, e.err);
                    e.bv = basis_at(1'b1, deg_v, uniq_v, col_index, v_param, e.err);
                    p = (longint'(e.bu) * e.bv + 32768) >> FRAC_BITS;
                    e.prod = val_t'(p);
                    expected_basis = {expected_basis, e};
                end
            end
        end
    end

endmodule

// ===== sim/bspline_tensor_basis_eval_test.sv =====
`timescale 1ns / 100ps

module bspline_tensor_basis_eval_test;
    import bst_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 40000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 done;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic [MODE_W-1:0]    mode;
    logic [IDX_W-1:0]     knot_slot;
    logic [VAL_W-1:0]     knot_value;
    logic [IDX_W-1:0]     row_index;
    logic [IDX_W-1:0]     col_index;
    logic [VAL_W-1:0]     u_param;
    logic [VAL_W-1:0]     v_param;
    logic [VAL_W-1:0]     basis_u_value;
    logic [VAL_W-1:0]     basis_v_value;
    logic [VAL_W-1:0]     product_value;
    logic                 index_error;
    int                   fail_count;
    int                   pending;

    int   sender_idle_pct;
    int   cur_deg_u, cur_deg_v, cur_uniq_u, cur_uniq_v;
    val_t knot_u_copy [0:63];
    val_t knot_v_copy [0:63];
    int   quiet_cycles;

    bspline_tensor_basis_eval i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .mode(mode), .knot_slot(knot_slot), .knot_value(knot_value),
        .row_index(row_index), .col_index(col_index),
        .u_param(u_param), .v_param(v_param),
        .basis_u_value(basis_u_value), .basis_v_value(basis_v_value),
        .product_value(product_value), .index_error(index_error)
    );

    bspline_tensor_basis_eval_checker i_checker (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if ((start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("bspline_tensor_basis_eval regression: fail");
            $finish;
        end
    end

    // Presents one request and returns at the edge that takes it; start stays high.
    task automatic send_request(input logic [MODE_W-1:0] m, input int slot, input int kval,
                                input int row, input int col, input int u, input int v);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= m;
        knot_slot  <= slot[IDX_W-1:0];
        knot_value <= kval[VAL_W-1:0];
        row_index  <= row[IDX_W-1:0];
        col_index  <= col[IDX_W-1:0];
        u_param    <= u[VAL_W-1:0];
        v_param    <= v[VAL_W-1:0];
        do @(posedge clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);
    endtask

    // Clamped, sorted knot vector: degree+1 zeros, rising interior, ones to the end.
    // Only the slots inside the full knot count are sent; evaluation never reads past it.
    task automatic load_knots(input logic dir_v, input int deg, input int uniq);
        val_t kv [0:63];
        int   total;
        int   lo;
        total = uniq + 2 * deg;
        lo = 0;
        for (int i = 0; i < 64; i++) begin
            if (i <= deg)
                kv[i] = '0;
            else if (i >= total - deg - 1)
                kv[i] = ONE_FX;
            else begin
                // Repeated interior knots give zero spans now and then.
                if ($urandom_range(3) != 0)
                    lo = $urandom_range(lo, lo + (65536 - lo) / 4);
                kv[i] = val_t'(lo);
            end
            if (dir_v)
                knot_v_copy[i] = kv[i];
            else
                knot_u_copy[i] = kv[i];
            if (i < total)
                send_request(dir_v ? MODE_LOAD_V : MODE_LOAD_U, i, kv[i], 0, 0, 0, 0);
        end
    endtask

    task automatic set_phase(input int du, input int dv, input int nu, input int nv);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_DEGREE_U;
        cfg_wdata <= CFG_W'(du);
        @(posedge clk);
        cfg_index <= CFG_DEGREE_V;
        cfg_wdata <= CFG_W'(dv);
        @(posedge clk);
        cfg_index <= CFG_UNIQUE_U;
        cfg_wdata <= CFG_W'(nu);
        @(posedge clk);
        cfg_index <= CFG_UNIQUE_V;
        cfg_wdata <= CFG_W'(nv);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_deg_u = du;
        cur_deg_v = dv;
        cur_uniq_u = nu;
        cur_uniq_v = nv;
        load_knots(1'b0, du, nu);
        load_knots(1'b1, dv, nv);
    endtask

    function automatic int pick_param(input logic dir_v);
        case ($urandom_range(9))
            0: return 0;
            1: return 65536;
            2: return $urandom_range(131071);
            3: return dir_v ? knot_v_copy[$urandom_range(63)] : knot_u_copy[$urandom_range(63)];
            default: return $urandom_range(65536);
        endcase
    endfunction

    function automatic int pick_index(input int deg, input int uniq);
        if ($urandom_range(9) == 0)
            return $urandom_range(63);
        return $urandom_range(uniq + deg);
    endfunction

    task automatic random_request();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            send_request(MODE_LOAD_U, $urandom_range(63),
                         $urandom_range(1) ? $urandom_range(131071) : $urandom_range(65536),
                         0, 0, 0, 0);
        else if (sel < 14)
            send_request(MODE_LOAD_V, $urandom_range(63), $urandom_range(131071), 0, 0, 0, 0);
        else begin
            if (sel < 17)
                send_request(MODE_NONE, $urandom_range(63), $urandom_range(131071),
                             $urandom_range(63), $urandom_range(63),
                             $urandom_range(131071), $urandom_range(131071));
            send_request(MODE_EVAL, $urandom_range(63), $urandom_range(131071),
                         pick_index(cur_deg_u, cur_uniq_u), pick_index(cur_deg_v, cur_uniq_v),
                         pick_param(1'b0), pick_param(1'b1));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        mode = MODE_NONE;
        knot_slot = '0;
        knot_value = '0;
        row_index = '0;
        col_index = '0;
        u_param = '0;
        v_param = '0;
        quiet_cycles = 0;
        sender_idle_pct = 10;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_phase(3, 2, 5, 4);
        send_request(MODE_EVAL, 0, 0, 0, 0, 0, 0);
        send_request(MODE_EVAL, 0, 0, 63, 63, 65536, 65536);
        send_request(MODE_EVAL, 0, 0, 6, 4, 65536, 65536);
        send_request(MODE_EVAL, 0, 0, 5, 3, 131071, 131071);
        send_request(MODE_EVAL, 0, 0, 2, 1, knot_u_copy[4], knot_v_copy[3]);
        send_request(MODE_EVAL, 0, 0, 4, 2, 65535, 1);
        send_request(MODE_NONE, 63, 131071, 63, 63, 131071, 131071);
        send_request(MODE_LOAD_U, 63, 131071, 0, 0, 0, 0);
        send_request(MODE_LOAD_V, 63, 0, 0, 0, 0, 0);
        send_request(MODE_EVAL, 0, 0, 1, 1, 32768, 43690);
        // Overwrite interior knot slot 4 with a tiny value.
        send_request(MODE_LOAD_U, 4, 1, 0, 0, 0, 0);
        send_request(MODE_EVAL, 0, 0, 1, 0, 2, 0);

        for (int ph = 0; ph < 11; ph++) begin
            if (ph == 0)
                set_phase(0, 7, 2, 64);
            else if (ph == 1)
                set_phase(7, 0, 64, 2);
            else if (ph == 2)
                set_phase(1, 1, 2, 2);
            else
                set_phase($urandom_range(3), $urandom_range(3),
                          $urandom_range(2, 24), $urandom_range(2, 12));
            sender_idle_pct = (ph < 4) ? 10 : (ph < 8) ? 77 : 0;
            for (int n = 0; n < 12; n++) begin
                if (ph == 5 && n == 6)
                    drain();
                random_request();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("bspline_tensor_basis_eval regression: pass");
        else
            $display("bspline_tensor_basis_eval regression: fail");
        $finish;
    end

endmodule
